// ===== rtl/ghm_pkg.sv =====
// ----------------------------------------------------------------------------
// ghm_pkg - shared types and constants for the gray horizontal mirror
// Pixel request and result formats, luma coefficients, queue sizes.
// ----------------------------------------------------------------------------
package ghm_pkg;

  // Input request kind
  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // Input request: one RGB pixel or a drain tick
  typedef struct packed {
    func_e      func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  // Result: mirrored gray pixel
  typedef struct packed {
    logic [7:0] gray;
    logic       row_end;
  } gray_out_t;

  // Control bits of one row store operation
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic row_end;
  } op_ctl_t;

  // Configuration register
  localparam int         CFG_W       = 11;
  localparam logic [10:0] WIDTH_RESET = 11'd1024;

  // BT.601 luma weights in 0.16 unsigned, summing to 65536
  localparam int          PROD_W = 24;
  localparam logic [15:0] COEF_R = 16'd19595;
  localparam logic [15:0] COEF_G = 16'd38470;
  localparam logic [15:0] COEF_B = 16'd7471;
  localparam int          GRAY_W = 8;

  // Operation queue and result queue sizes
  localparam int OP_DEPTH   = 4;
  localparam int OP_CNT_W   = 3;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_CNT_W  = 3;

endpackage

// ===== rtl/gray_horizontal_mirror.sv =====
// ----------------------------------------------------------------------------
// gray_horizontal_mirror - RGB to luma with horizontal row mirroring
// Converts RGB pixels to BT.601 luma and emits each row right to left,
// one row behind the input, through a ping-pong row store.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// pixel     in         push / full             pixel_i  (func, red, green, blue)
// result    out        pop / empty             result_o (gray, row_end)
// config    in         cfg_valid_i/cfg_ready_o cfg_width_i (image width)
//
// Sustained rate is one request per clock while full is low; the row store
// does one read and one write per cycle. A result passes the stage-1 products,
// op queue, registered store read and result queue on its way to result_o.
// Reset clears all control state; row store contents are not cleared.
// A stalled result side fills the result and op queues, then raises full.
// ----------------------------------------------------------------------------
module gray_horizontal_mirror #(
  parameter int MAX_ROW_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  ghm_pkg::pixel_in_t        pixel_i,
  output logic                      empty,
  input  logic                      pop,
  output ghm_pkg::gray_out_t        result_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ghm_pkg::CFG_W-1:0] cfg_width_i
);

  localparam int CW  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int AW  = CW + 1;
  localparam int OPW = $bits(ghm_pkg::op_ctl_t) + 2 * AW + ghm_pkg::GRAY_W;

  logic [ghm_pkg::CFG_W-1:0]    width_q;
  logic [ghm_pkg::OP_CNT_W-1:0] op_count;
  logic                         op_push, op_pop, op_empty;
  ghm_pkg::op_ctl_t             fe_ctl, be_ctl;
  logic [AW-1:0]                fe_rd_addr, fe_wr_addr;
  logic [AW-1:0]                be_rd_addr, be_wr_addr;
  logic [ghm_pkg::GRAY_W-1:0]   fe_wr_data, be_wr_data;
  logic [OPW-1:0]               op_wdata, op_rdata;

  // Image width register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ghm_pkg::WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= cfg_width_i;
    end
  end

  // Front end
  ghm_front #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .pixel_i      (pixel_i),
    .width_i      (width_q),
    .op_count_i   (op_count),
    .op_push_o    (op_push),
    .op_ctl_o     (fe_ctl),
    .op_rd_addr_o (fe_rd_addr),
    .op_wr_addr_o (fe_wr_addr),
    .op_wr_data_o (fe_wr_data)
  );

  // Op queue between front and back
  assign op_wdata = {fe_ctl, fe_rd_addr, fe_wr_addr, fe_wr_data};

  ghm_fifo #(
    .WIDTH (OPW),
    .DEPTH (ghm_pkg::OP_DEPTH)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .wdata_i (op_wdata),
    .pop_i   (op_pop),
    .rdata_o (op_rdata),
    .empty_o (op_empty),
    .count_o (op_count)
  );

  assign {be_ctl, be_rd_addr, be_wr_addr, be_wr_data} = op_rdata;

  // Back end
  ghm_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_empty_i   (op_empty),
    .op_ctl_i     (be_ctl),
    .op_rd_addr_i (be_rd_addr),
    .op_wr_addr_i (be_wr_addr),
    .op_wr_data_i (be_wr_data),
    .op_pop_o     (op_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result_o)
  );

endmodule

// ===== rtl/ghm_ram.sv =====
// ----------------------------------------------------------------------------
// ghm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ghm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ghm_fifo.sv =====
// ----------------------------------------------------------------------------
// ghm_fifo - small synchronous FIFO
// Flop storage, head read, occupancy count for credit-based flow control.
// ----------------------------------------------------------------------------
module ghm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_pop;

  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    count_d = count_q + CW'(push_i) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/ghm_front.sv =====
// ----------------------------------------------------------------------------
// ghm_front - request intake and row bookkeeping
// Tracks write/read columns and ping-pong half, computes luma, and issues
// one row store operation per request that touches the store.
// ----------------------------------------------------------------------------
module ghm_front #(
  parameter int MAX_ROW_WIDTH = 1024,
  localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1,
  localparam int AW = CW + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  ghm_pkg::pixel_in_t             pixel_i,
  input  logic [ghm_pkg::CFG_W-1:0]      width_i,
  input  logic [ghm_pkg::OP_CNT_W-1:0]   op_count_i,
  output logic                           op_push_o,
  output ghm_pkg::op_ctl_t               op_ctl_o,
  output logic [AW-1:0]                  op_rd_addr_o,
  output logic [AW-1:0]                  op_wr_addr_o,
  output logic [ghm_pkg::GRAY_W-1:0]     op_wr_data_o
);

  localparam int WW = CW + 1;
  localparam int PW = ghm_pkg::PROD_W;

  logic [CW-1:0]     wcol_q, wcol_d;
  logic [CW-1:0]     rcol_q, rcol_d;
  logic              half_q, half_d;
  logic              pend_q, pend_d;
  logic [WW-1:0]     used_width;
  logic              row_done;
  logic              accept;
  ghm_pkg::op_ctl_t  ctl_d;

  logic              s1_valid_q;
  ghm_pkg::op_ctl_t  s1_ctl_q;
  logic [AW-1:0]     s1_rd_addr_q;
  logic [AW-1:0]     s1_wr_addr_q;
  logic [PW-1:0]     prod_r_q, prod_g_q, prod_b_q;
  logic [PW-1:0]     luma_sum;

  // Width in use: zero acts as one, clamp to the store size
  always_comb begin
    if (width_i == '0) begin
      used_width = WW'(1);
    end else if (32'(width_i) > MAX_ROW_WIDTH) begin
      used_width = WW'(MAX_ROW_WIDTH);
    end else begin
      used_width = WW'(width_i);
    end
  end

  // Credit check: the stage-1 op and this one must fit in the op queue
  assign full_o   = (32'(op_count_i) + 32'(s1_valid_q)) >= ghm_pkg::OP_DEPTH;
  assign accept   = push_i && !full_o;
  assign row_done = ({1'b0, wcol_q} + WW'(1)) >= used_width;

  // Column, half and pending bookkeeping
  always_comb begin
    wcol_d = wcol_q;
    rcol_d = rcol_q;
    half_d = half_q;
    pend_d = pend_q;
    ctl_d  = '0;
    if (accept) begin
      // readout of the previous row, right to left
      if (pend_q) begin
        ctl_d.rd_en   = 1'b1;
        ctl_d.row_end = (rcol_q == '0);
        if (rcol_q == '0) begin
          pend_d = 1'b0;
        end else begin
          rcol_d = rcol_q - 1'b1;
        end
      end
      // write of the new pixel; a finished row swaps halves
      if (pixel_i.func == ghm_pkg::FUNC_PIXEL) begin
        ctl_d.wr_en = 1'b1;
        if (row_done) begin
          half_d = ~half_q;
          wcol_d = '0;
          pend_d = 1'b1;
          rcol_d = CW'(used_width - WW'(1));
        end else begin
          wcol_d = wcol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q     <= '0;
      rcol_q     <= '0;
      half_q     <= 1'b0;
      pend_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      wcol_q     <= wcol_d;
      rcol_q     <= rcol_d;
      half_q     <= half_d;
      pend_q     <= pend_d;
      s1_valid_q <= ctl_d.rd_en | ctl_d.wr_en;
    end
  end

  // Stage 1: op fields and luma products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q     <= ctl_d;
      s1_rd_addr_q <= {~half_q, rcol_q};
      s1_wr_addr_q <= {half_q, wcol_q};
      prod_r_q     <= PW'(ghm_pkg::COEF_R) * PW'(pixel_i.red);
      prod_g_q     <= PW'(ghm_pkg::COEF_G) * PW'(pixel_i.green);
      prod_b_q     <= PW'(ghm_pkg::COEF_B) * PW'(pixel_i.blue);
    end
  end

  // Weights sum to 1.0, so the sum never exceeds 255 in the integer part
  assign luma_sum = prod_r_q + prod_g_q + prod_b_q;

  assign op_push_o    = s1_valid_q;
  assign op_ctl_o     = s1_ctl_q;
  assign op_rd_addr_o = s1_rd_addr_q;
  assign op_wr_addr_o = s1_wr_addr_q;
  assign op_wr_data_o = luma_sum[PW-1 -: ghm_pkg::GRAY_W];

`ifndef SYNTH
  // Op queue never overflows on a stage-1 push
  a_op_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (32'(op_count_i) < ghm_pkg::OP_DEPTH))
    else $error("op queue overflow");

  // Columns stay inside one store half
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wcol_q) < MAX_ROW_WIDTH) && (32'(rcol_q) < MAX_ROW_WIDTH))
    else $error("column out of range");

  // A finished row starts a readout from the other half
  a_row_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (pixel_i.func == ghm_pkg::FUNC_PIXEL) && row_done)
      |=> (pend_q && (wcol_q == '0) && (half_q != $past(half_q))))
    else $error("row completion not taken");
`endif

endmodule

// ===== rtl/ghm_back.sv =====
// ----------------------------------------------------------------------------
// ghm_back - row store access and result queue
// Executes queued row store operations in order and buffers read results.
// ----------------------------------------------------------------------------
module ghm_back #(
  parameter int MAX_ROW_WIDTH = 1024,
  localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1,
  localparam int AW = CW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_empty_i,
  input  ghm_pkg::op_ctl_t           op_ctl_i,
  input  logic [AW-1:0]              op_rd_addr_i,
  input  logic [AW-1:0]              op_wr_addr_i,
  input  logic [ghm_pkg::GRAY_W-1:0] op_wr_data_i,
  output logic                       op_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output ghm_pkg::gray_out_t         result_o
);

  localparam int RW = $bits(ghm_pkg::gray_out_t);

  logic                          space;
  logic                          ram_we, ram_re;
  logic [ghm_pkg::GRAY_W-1:0]    ram_rdata;
  logic                          inflight_q;
  logic                          row_end_q;
  logic [ghm_pkg::OUT_CNT_W-1:0] out_count;
  logic [RW-1:0]                 out_rdata;
  ghm_pkg::gray_out_t            out_wdata;

  // Issue a read only with room for it and the one in flight
  assign space    = (32'(out_count) + 32'(inflight_q)) < (ghm_pkg::OUT_DEPTH - 1);
  assign op_pop_o = !op_empty_i && (!op_ctl_i.rd_en || space);
  assign ram_we   = op_pop_o && op_ctl_i.wr_en;
  assign ram_re   = op_pop_o && op_ctl_i.rd_en;

  ghm_ram #(
    .WIDTH (ghm_pkg::GRAY_W),
    .DEPTH (2 ** AW)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_wr_addr_i),
    .wdata_i (op_wr_data_i),
    .re_i    (ram_re),
    .raddr_i (op_rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // Read in flight tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      row_end_q <= op_ctl_i.row_end;
    end
  end

  // Result queue
  assign out_wdata.gray    = ram_rdata;
  assign out_wdata.row_end = row_end_q;

  ghm_fifo #(
    .WIDTH (RW),
    .DEPTH (ghm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (inflight_q),
    .wdata_i (out_wdata),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign result_o = ghm_pkg::gray_out_t'(out_rdata);

`ifndef SYNTH
  // Read and write of one op always hit opposite halves
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (op_rd_addr_i[AW-1] != op_wr_addr_i[AW-1]))
    else $error("row store read/write collision");

  // Result queue never overflows
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> (32'(out_count) < ghm_pkg::OUT_DEPTH))
    else $error("result queue overflow");
`endif

endmodule
